[rtl/core/disjoint_set_union_core_defines.svh]
// Assertion macros shared by the disjoint-set union core RTL.
`ifndef DISJOINT_SET_UNION_CORE_DEFINES_SVH
`define DISJOINT_SET_UNION_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define DSU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("disjoint set union core: assertion failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define DSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("disjoint set union core: assertion failed");
`else
`define DSU_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define DSU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/core/dsu_pkg.sv]
// Shared types and constants for the disjoint-set union core.
`timescale 1ns / 1ps
`default_nettype none

package dsu_pkg;

    localparam int MaxElementsDefault = 64;
    localparam int ActiveResetValue   = 64;
    localparam int IndexWidth         = 6;
    localparam int ActiveWidth        = 7;
    localparam int CountWidth         = 7;
    localparam int ApbAddrWidth       = 3;
    localparam int ApbDataWidth       = 32;

    // Register index as decoded from the word address bit of paddr.
    localparam logic [0:0] RegActiveElements = 1'b0;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ_A,
        S_READ_B,
        S_COMPARE,
        S_SWEEP,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

[rtl/core/dsu_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module dsu_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/core/disjoint_set_union_core.sv]
// Top level of the quick-find disjoint-set union core.
`timescale 1ns / 1ps
`default_nettype none
`include "disjoint_set_union_core_defines.svh"

// Quick-find union-find over up to MAX_ELEMENTS elements. Every element keeps
// a component label in a label RAM; a transaction on the input channel names
// two elements and adds an edge between them. When both indices are below
// active_elements and their labels differ, a sweep walks entries 0 through
// active_elements-1, one entry per cycle, and relabels every entry carrying
// the label of element_b with the label of element_a; the component count
// then drops by one. Each input transaction yields exactly one output
// transaction with merged, components_left and bad_index unless a register
// write abandons it. An index at or above active_elements sets bad_index and
// leaves all state alone. A merging edge goes through two label reads, one
// compare, the sweep and one handover into the output register; an edge
// inside one component skips the sweep and a bad index goes straight to the
// handover. The single RAM port pair and the one shared comparator set this
// order. o_stall stays high for the whole item. After reset and after every
// write of active_elements a clearing pass rewrites each active label with
// its own index, and no input transaction is taken during it; register writes
// are taken at any time. Register 0 (byte addresses 0-3) is active_elements;
// only pwdata[6:0] is used; a 0 is stored as 1 and a value above
// MAX_ELEMENTS as MAX_ELEMENTS. Addresses 4-7 ignore writes and read as zero.
module disjoint_set_union_core #(
    parameter int MAX_ELEMENTS = dsu_pkg::MaxElementsDefault
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [dsu_pkg::ApbAddrWidth-1:0]  paddr,
    input  wire logic [dsu_pkg::ApbDataWidth-1:0]  pwdata,
    output logic      [dsu_pkg::ApbDataWidth-1:0]  prdata,
    output logic                                   pready,
    // Input channel
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [dsu_pkg::IndexWidth-1:0]    i_element_a,
    input  wire logic [dsu_pkg::IndexWidth-1:0]    i_element_b,
    // Output channel
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic                                   o_merged,
    output logic      [dsu_pkg::CountWidth-1:0]    o_components_left,
    output logic                                   o_bad_index
);

    localparam int AW   = $clog2(MAX_ELEMENTS);
    localparam int AcW  = dsu_pkg::ActiveWidth;
    localparam int CnW  = dsu_pkg::CountWidth;
    localparam int IxW  = dsu_pkg::IndexWidth;
    localparam int DW   = dsu_pkg::ApbDataWidth;
    localparam int CntW = (AW > AcW) ? AW : AcW;
    localparam int ResetActiveInt = (MAX_ELEMENTS < dsu_pkg::ActiveResetValue) ?
                                    MAX_ELEMENTS : dsu_pkg::ActiveResetValue;
    localparam logic [AcW-1:0] ActiveReset = AcW'(ResetActiveInt);

    // Control state.
    dsu_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_idx,    n_idx;
    logic [AcW-1:0]  r_active, n_active;
    logic [CnW-1:0]  r_count,  n_count;
    logic            r_ovalid, n_ovalid;

    // Item payload.
    logic [IxW-1:0]  r_a, n_a;
    logic [IxW-1:0]  r_b, n_b;
    logic [AW-1:0]   r_keep, n_keep;
    logic [AW-1:0]   r_gone, n_gone;
    logic            r_res_merged, n_res_merged;
    logic            r_res_bad,    n_res_bad;
    logic            r_merged,     n_merged;
    logic            r_bad,        n_bad;
    logic [CnW-1:0]  r_left,       n_left;

    // Label RAM access.
    logic            w_we;
    logic [AW-1:0]   w_waddr;
    logic [AW-1:0]   w_wdata;
    logic [AW-1:0]   w_raddr;
    logic [AW-1:0]   w_rdata;

    // Shared comparator and helpers.
    logic [AW-1:0]   w_cmp_ref;
    logic            w_hit;
    logic            w_last;
    logic            w_accept;
    logic            w_in_bad;
    logic            w_cfg_wr;
    logic [AcW-1:0]  w_cfg_raw;
    logic [AcW-1:0]  w_cfg_value;

    dsu_ram #(
        .WIDTH (AW),
        .DEPTH (MAX_ELEMENTS)
    ) u_label_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Configuration port. The word address bit selects the register.
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite &&
                       (paddr[2] == dsu_pkg::RegActiveElements);
    assign w_cfg_raw = pwdata[AcW-1:0];
    assign prdata    = (paddr[2] == dsu_pkg::RegActiveElements) ? DW'(r_active) : '0;

    always_comb begin
        if (w_cfg_raw == '0) begin
            w_cfg_value = AcW'(1);
        end else if (int'(w_cfg_raw) > MAX_ELEMENTS) begin
            w_cfg_value = AcW'(MAX_ELEMENTS);
        end else begin
            w_cfg_value = w_cfg_raw;
        end
    end

    // Handshake and range check on the incoming edge.
    assign o_stall  = (r_state != dsu_pkg::S_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign w_in_bad = ({1'b0, i_element_a} >= r_active) ||
                      ({1'b0, i_element_b} >= r_active);

    // One comparator serves both the label check and every step of the sweep.
    assign w_cmp_ref = (r_state == dsu_pkg::S_COMPARE) ? r_keep : r_gone;
    assign w_hit     = (w_rdata == w_cmp_ref);

    // The index counter has reached the last active entry.
    assign w_last = ((CntW'(r_idx) + CntW'(1)) == CntW'(r_active));

    assign o_valid           = r_ovalid;
    assign o_merged          = r_merged;
    assign o_components_left = r_left;
    assign o_bad_index       = r_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dsu_pkg::S_CLEAR;
            r_idx    <= '0;
            r_active <= ActiveReset;
            r_count  <= CnW'(ActiveReset);
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_active <= n_active;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a          <= n_a;
        r_b          <= n_b;
        r_keep       <= n_keep;
        r_gone       <= n_gone;
        r_res_merged <= n_res_merged;
        r_res_bad    <= n_res_bad;
        r_merged     <= n_merged;
        r_bad        <= n_bad;
        r_left       <= n_left;
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_active     = r_active;
        n_count      = r_count;
        n_ovalid     = r_ovalid;
        n_a          = r_a;
        n_b          = r_b;
        n_keep       = r_keep;
        n_gone       = r_gone;
        n_res_merged = r_res_merged;
        n_res_bad    = r_res_bad;
        n_merged     = r_merged;
        n_bad        = r_bad;
        n_left       = r_left;
        w_we         = 1'b0;
        w_waddr      = r_idx;
        w_wdata      = r_keep;
        w_raddr      = r_idx;

        // The output register empties when the consumer takes the result.
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            dsu_pkg::S_CLEAR: begin
                w_we    = 1'b1;
                w_wdata = r_idx;
                if (w_last) begin
                    n_idx   = '0;
                    n_state = dsu_pkg::S_IDLE;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            dsu_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_a          = i_element_a;
                    n_b          = i_element_b;
                    n_res_merged = 1'b0;
                    n_res_bad    = w_in_bad;
                    n_state      = w_in_bad ? dsu_pkg::S_DONE : dsu_pkg::S_READ_A;
                end
            end
            dsu_pkg::S_READ_A: begin
                w_raddr = AW'(r_a);
                n_state = dsu_pkg::S_READ_B;
            end
            dsu_pkg::S_READ_B: begin
                w_raddr = AW'(r_b);
                n_keep  = w_rdata;
                n_state = dsu_pkg::S_COMPARE;
            end
            dsu_pkg::S_COMPARE: begin
                if (w_hit) begin
                    n_state = dsu_pkg::S_DONE;
                end else begin
                    n_gone  = w_rdata;
                    w_raddr = '0;
                    n_idx   = '0;
                    n_state = dsu_pkg::S_SWEEP;
                end
            end
            dsu_pkg::S_SWEEP: begin
                // Data for entry r_idx arrives now; the next entry is fetched.
                w_we    = w_hit;
                w_waddr = r_idx;
                w_wdata = r_keep;
                w_raddr = r_idx + AW'(1);
                if (w_last) begin
                    n_idx        = '0;
                    n_count      = (r_count != '0) ? (r_count - CnW'(1)) : r_count;
                    n_res_merged = 1'b1;
                    n_state      = dsu_pkg::S_DONE;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            dsu_pkg::S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    n_merged = r_res_merged;
                    n_bad    = r_res_bad;
                    n_left   = r_count;
                    n_state  = dsu_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dsu_pkg::S_CLEAR;
                n_idx   = '0;
            end
        endcase

        // A register write restarts the labels and the count from scratch.
        if (w_cfg_wr) begin
            n_active = w_cfg_value;
            n_count  = CnW'(w_cfg_value);
            n_idx    = '0;
            n_state  = dsu_pkg::S_CLEAR;
        end
    end

    // The count stays between one and the number of active elements.
    `DSU_ASSERT_NOW(a_count_range, i_clk, i_rst_n, 1'b1, (r_count != '0) && (CntW'(r_count) <= CntW'(r_active)))
    // Finishing a sweep removes exactly one component.
    `DSU_ASSERT_NEXT(a_merge_decrements, i_clk, i_rst_n, (r_state == dsu_pkg::S_SWEEP) && w_last && !w_cfg_wr, r_count == ($past(r_count) - CnW'(1)))
    // Labels change only during the clearing pass or a relabel sweep.
    `DSU_ASSERT_NOW(a_write_window, i_clk, i_rst_n, w_we, (r_state == dsu_pkg::S_CLEAR) || (r_state == dsu_pkg::S_SWEEP))
    // A rejected edge never reports a merge.
    `DSU_ASSERT_NOW(a_bad_no_merge, i_clk, i_rst_n, r_ovalid, !(r_merged && r_bad))

endmodule

`default_nettype wire
